/* src/slcd_pkg.sv */
// Shared types, register indexes and the CRC-8 step for the sync/length/CRC-8 deframer.
// No dependencies; every other file of the block but slcd_ram imports this package.
package slcd_pkg;

  localparam int MAX_BODY_DEF = 64;
  localparam int LEN_W        = 7;
  localparam int BYTE_W       = 8;
  localparam int IDX_W        = 6;
  localparam int TICK_W       = 16;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_INDEX_W  = 2;

  localparam logic [BYTE_W-1:0] CRC_POLY = 8'hD5;

  localparam logic [BYTE_W-1:0] SYNC_VALUE_RST    = 8'd0;
  localparam logic [LEN_W-1:0]  MAX_LENGTH_RST    = 7'd64;
  localparam logic [TICK_W-1:0] TIMEOUT_TICKS_RST = 16'd100;

  localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_VALUE    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LENGTH    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_TICKS = 2'd2;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [BYTE_W-1:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] body_byte;
    logic [IDX_W-1:0]  byte_index;
    logic [LEN_W-1:0]  body_length;
    logic              crc_ok;
    logic              last;
  } out_item_t;

  // Control from the frame sequencer to the serial CRC unit.
  typedef struct packed {
    logic clear;
    logic start;
  } crc_ctl_t;

  // One bit of the MSB-first CRC-8 shift.
  function automatic logic [BYTE_W-1:0] crc_step(input logic [BYTE_W-1:0] crc);
    crc_step = crc[BYTE_W-1] ? ({crc[BYTE_W-2:0], 1'b0} ^ CRC_POLY)
                             : {crc[BYTE_W-2:0], 1'b0};
  endfunction

endpackage

/* src/slcd_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module slcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/slcd_crc_serial.sv */
// Bit-serial CRC-8 unit: folds one byte into the running CRC bit by bit.
// Depends on slcd_pkg.
module slcd_crc_serial (
  input  logic                     clk,
  input  logic                     rst,
  input  slcd_pkg::crc_ctl_t       ctl,
  input  logic [7:0]               din,
  output logic                     busy,
  output logic [7:0]               crc
);
  import slcd_pkg::*;

  logic [2:0] bit_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      bit_count <= '0;
      crc       <= '0;
    end else if (ctl.clear) begin
      busy      <= 1'b0;
      bit_count <= '0;
      crc       <= '0;
    end else if (ctl.start) begin
      // The byte is XORed in first, then shifted out one bit per cycle.
      busy      <= 1'b1;
      bit_count <= '0;
      crc       <= crc ^ din;
    end else if (busy) begin
      crc       <= crc_step(crc);
      bit_count <= bit_count + 3'd1;
      if (bit_count == 3'd7) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

/* src/sync_length_crc8_deframer.sv */
// Top level of the sync/length/body/CRC-8 frame receiver.
// Depends on slcd_pkg, slcd_ram and slcd_crc_serial.
//
//   Channel   Signals                          Direction  Word
//   input     in_valid, in_ready, in_item      in         cmd, rx_byte
//   output    out_valid, out_ready, out_item   out        one body byte with index and status
//   config    cfg_we, cfg_index, cfg_data      in         register write, no wait
//
// A tick, a sync byte, a length byte, the CRC byte and a zero-length filler byte are each taken
// in their accept cycle alone. A body byte covered by the CRC holds the input through its accept
// cycle, the single-bit steps of the serial CRC unit and the cycle in which the sequencer sees
// it go idle. At frame end each result is a body RAM read followed by a presented output word;
// no input is taken during that run.
// Reset is synchronous and returns the block to hunting with the reset register values; the
// body RAM is not cleared. A stalled output word holds the whole sequencer in place.
module sync_length_crc8_deframer #(
  parameter int MAX_BODY = slcd_pkg::MAX_BODY_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  slcd_pkg::in_item_t                 in_item,
  output logic                               out_valid,
  input  logic                               out_ready,
  output slcd_pkg::out_item_t                out_item,
  input  logic                               cfg_we,
  input  logic [slcd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [slcd_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import slcd_pkg::*;

  localparam int AW = $clog2(MAX_BODY);

  // Sequencer states. LEN, BODY and CRC_BYTE are the states of a partial frame that take input,
  // where ticks count toward the idle timeout.
  typedef enum logic [6:0] {
    ST_HUNT      = 7'b0000001,
    ST_LEN       = 7'b0000010,
    ST_BODY      = 7'b0000100,
    ST_CRC_WAIT  = 7'b0001000,
    ST_CRC_BYTE  = 7'b0010000,
    ST_EMIT_RD   = 7'b0100000,
    ST_EMIT_OUT  = 7'b1000000
  } state_t;

  state_t             state, state_next;
  logic [BYTE_W-1:0]  sync_value;
  logic [LEN_W-1:0]   max_length;
  logic [TICK_W-1:0]  timeout_ticks;
  logic [LEN_W-1:0]   frame_len, frame_len_next;
  logic [LEN_W-1:0]   write_pos, write_pos_next;
  logic [LEN_W-1:0]   emit_idx, emit_idx_next;
  logic [TICK_W-1:0]  idle_count, idle_next;
  logic               match, match_next;

  logic               in_fire;
  logic [TICK_W-1:0]  idle_inc;
  logic               len_fits;
  logic               emit_last;
  crc_ctl_t           crc_ctl;
  logic               crc_busy;
  logic [BYTE_W-1:0]  crc;
  logic               ram_we;
  logic               ram_re;
  logic [BYTE_W-1:0]  ram_rdata;

  // Configuration registers; writes to an index past the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_value    <= SYNC_VALUE_RST;
      max_length    <= MAX_LENGTH_RST;
      timeout_ticks <= TIMEOUT_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SYNC_VALUE:    sync_value    <= cfg_data[BYTE_W-1:0];
        CFG_MAX_LENGTH:    max_length    <= cfg_data[LEN_W-1:0];
        CFG_TIMEOUT_TICKS: timeout_ticks <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = (state == ST_HUNT) || (state == ST_LEN) || (state == ST_BODY) ||
                    (state == ST_CRC_BYTE);
  assign in_fire  = in_valid && in_ready;

  // The length must fit both the configured maximum and the physical store.
  assign len_fits = (in_item.rx_byte <= {1'b0, max_length}) &&
                    (in_item.rx_byte <= BYTE_W'(MAX_BODY));

  // A zero-length frame gives exactly one result.
  assign emit_last = (frame_len == '0) || ((emit_idx + LEN_W'(1)) == frame_len);

  always_comb begin
    state_next     = state;
    frame_len_next = frame_len;
    write_pos_next = write_pos;
    emit_idx_next  = emit_idx;
    idle_next      = idle_count;
    match_next     = match;
    crc_ctl        = '0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    idle_inc       = (idle_count == {TICK_W{1'b1}}) ? idle_count : idle_count + TICK_W'(1);

    if (in_fire) begin
      if (in_item.cmd == CMD_TICK) begin
        if (state == ST_HUNT) begin
          idle_next = '0;
        end else begin
          idle_next = idle_inc;
          if (idle_inc > timeout_ticks) begin
            // Idle timeout: the partial frame is discarded.
            state_next     = ST_HUNT;
            frame_len_next = '0;
            write_pos_next = '0;
            idle_next      = '0;
          end
        end
      end else begin
        idle_next = '0;
        case (state)
          ST_HUNT: begin
            if (in_item.rx_byte == sync_value) begin
              state_next = ST_LEN;
            end
          end
          ST_LEN: begin
            if (len_fits) begin
              frame_len_next = in_item.rx_byte[LEN_W-1:0];
              write_pos_next = '0;
              crc_ctl.clear  = 1'b1;
              state_next     = ST_BODY;
            end else begin
              state_next = ST_HUNT;
            end
          end
          ST_BODY: begin
            ram_we         = 1'b1;
            write_pos_next = write_pos + LEN_W'(1);
            if (write_pos < frame_len) begin
              crc_ctl.start = 1'b1;
              state_next    = ST_CRC_WAIT;
            end else begin
              // Only a zero-length frame gets here: its filler byte skips the CRC.
              state_next = ST_CRC_BYTE;
            end
          end
          ST_CRC_BYTE: begin
            match_next    = (crc == in_item.rx_byte);
            emit_idx_next = '0;
            state_next    = ST_EMIT_RD;
          end
          default: ;
        endcase
      end
    end

    case (state)
      ST_CRC_WAIT: begin
        if (!crc_busy) begin
          state_next = (write_pos >= frame_len) ? ST_CRC_BYTE : ST_BODY;
        end
      end
      ST_EMIT_RD: begin
        ram_re     = 1'b1;
        state_next = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        if (out_ready) begin
          if (emit_last) begin
            state_next = ST_HUNT;
          end else begin
            emit_idx_next = emit_idx + LEN_W'(1);
            state_next    = ST_EMIT_RD;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_HUNT;
      frame_len  <= '0;
      write_pos  <= '0;
      emit_idx   <= '0;
      idle_count <= '0;
      match      <= 1'b0;
    end else begin
      state      <= state_next;
      frame_len  <= frame_len_next;
      write_pos  <= write_pos_next;
      emit_idx   <= emit_idx_next;
      idle_count <= idle_next;
      match      <= match_next;
    end
  end

  slcd_crc_serial u_crc (
    .clk  (clk),
    .rst  (rst),
    .ctl  (crc_ctl),
    .din  (in_item.rx_byte),
    .busy (crc_busy),
    .crc  (crc)
  );

  // Body store. Every entry read at frame end was written earlier in the same frame.
  slcd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_BODY)
  ) u_body_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(write_pos)),
    .wdata (in_item.rx_byte),
    .re    (ram_re),
    .raddr (AW'(emit_idx)),
    .rdata (ram_rdata)
  );

  // The RAM output holds between reads, so it serves as the output data register.
  assign out_valid            = (state == ST_EMIT_OUT);
  assign out_item.body_byte   = (frame_len == '0) ? '0 : ram_rdata;
  assign out_item.byte_index  = emit_idx[IDX_W-1:0];
  assign out_item.body_length = frame_len;
  assign out_item.crc_ok      = match;
  assign out_item.last        = emit_last;

  // No input word is taken while a result is presented.
  assert property (@(posedge clk) disable iff (rst) out_valid |-> !in_ready)
    else $error("input accepted during result run");

  // The serial CRC unit only runs while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (rst) crc_busy |-> (state == ST_CRC_WAIT))
    else $error("CRC unit busy outside its wait state");

  // The final result of a frame returns the block to hunting.
  assert property (@(posedge clk) disable iff (rst)
                   (out_valid && out_ready && out_item.last) |=> (state == ST_HUNT))
    else $error("no return to hunting after last result");

  // The write position never passes the frame length while body bytes are taken.
  assert property (@(posedge clk) disable iff (rst)
                   (state == ST_BODY) |-> (write_pos <= frame_len))
    else $error("write position past frame length");

endmodule

/* test/slcd_frame_checker.sv */
// Frame checker for the sync/length/CRC-8 deframer: watches the three ports, predicts the
// body words of each finished frame and compares them with the output channel.
// Depends on slcd_pkg for the word types, register indexes and command codes.
module slcd_frame_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  slcd_pkg::in_item_t               in_item,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  slcd_pkg::out_item_t              out_item,
  input  logic                             cfg_we,
  input  logic [slcd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [slcd_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               fail_count,
  output int                               pending
);
  import slcd_pkg::*;

  localparam int BODY_DEPTH = 64;

  typedef enum logic [1:0] {HUNT, GET_LEN, GET_BODY, GET_CRC} rx_phase_t;

  logic [BYTE_W-1:0] sync_byte;
  logic [LEN_W-1:0]  len_limit;
  logic [TICK_W-1:0] tick_limit;

  rx_phase_t         rx_phase;
  logic [LEN_W-1:0]  frame_len;
  logic [LEN_W-1:0]  fill_pos;
  logic [BYTE_W-1:0] body_crc;
  logic [BYTE_W-1:0] body_mem [BODY_DEPTH];
  logic [TICK_W-1:0] idle_ticks;

  out_item_t body_words_due [$];

  initial fail_count = 0;
  initial pending = 0;

  function automatic logic [BYTE_W-1:0] crc8_d5(input logic [BYTE_W-1:0] crc,
                                                input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  task automatic abandon_frame();
    rx_phase   = HUNT;
    frame_len  = '0;
    fill_pos   = '0;
    idle_ticks = '0;
  endtask

  // Advances the predicted receiver by one accepted input word.
  task automatic predict_rx(input in_item_t w);
    out_item_t r;
    logic      ok;
    int        n;
    if (w.cmd == CMD_TICK) begin
      if (rx_phase != HUNT) begin
        if (idle_ticks != '1) idle_ticks++;
        if (idle_ticks > tick_limit) abandon_frame();
      end else begin
        idle_ticks = '0;
      end
      return;
    end
    idle_ticks = '0;
    case (rx_phase)
      HUNT: begin
        if (w.rx_byte == sync_byte) rx_phase = GET_LEN;
      end
      GET_LEN: begin
        if (w.rx_byte <= {1'b0, len_limit} && w.rx_byte <= 8'(BODY_DEPTH)) begin
          frame_len = w.rx_byte[LEN_W-1:0];
          fill_pos  = '0;
          body_crc  = '0;
          rx_phase  = GET_BODY;
        end else begin
          rx_phase = HUNT;
        end
      end
      GET_BODY: begin
        if (fill_pos < BODY_DEPTH) begin
          body_mem[fill_pos[IDX_W-1:0]] = w.rx_byte;
          if (fill_pos < frame_len) body_crc = crc8_d5(body_crc, w.rx_byte);
          fill_pos++;
        end
        if (fill_pos >= frame_len) rx_phase = GET_CRC;
      end
      default: begin
        ok       = (body_crc == w.rx_byte);
        rx_phase = HUNT;
        // A zero-length frame still reports one word with a zero body byte.
        n = (frame_len == 0) ? 1 : int'(frame_len);
        for (int k = 0; k < n; k++) begin
          r.body_byte   = (frame_len == 0) ? '0 : body_mem[k];
          r.byte_index  = IDX_W'(k);
          r.body_length = frame_len;
          r.crc_ok      = ok;
          r.last        = (k == n - 1);
          body_words_due.push_back(r);
        end
      end
    endcase
  endtask

  task automatic cmp_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      fail_count++;
    end
  endtask

  task automatic check_word(input out_item_t got);
    out_item_t want;
    if (body_words_due.size() == 0) begin
      $display("%0t: unexpected output word, expected none, actual %0h", $time, got);
      fail_count++;
      return;
    end
    want = body_words_due.pop_front();
    cmp_field("body_byte",   want.body_byte,   got.body_byte);
    cmp_field("byte_index",  want.byte_index,  got.byte_index);
    cmp_field("body_length", want.body_length, got.body_length);
    cmp_field("crc_ok",      want.crc_ok,      got.crc_ok);
    cmp_field("last",        want.last,        got.last);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      sync_byte  = SYNC_VALUE_RST;
      len_limit  = MAX_LENGTH_RST;
      tick_limit = TIMEOUT_TICKS_RST;
      body_crc   = '0;
      abandon_frame();
      body_words_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SYNC_VALUE:    sync_byte  = cfg_data[BYTE_W-1:0];
          CFG_MAX_LENGTH:    len_limit  = cfg_data[LEN_W-1:0];
          CFG_TIMEOUT_TICKS: tick_limit = cfg_data[TICK_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) check_word(out_item);
      if (in_valid && in_ready) predict_rx(in_item);
    end
    pending <= body_words_due.size();
  end

endmodule

/* test/testbench.sv */
// Top of the deframer testbench: clock, reset, stimulus, output back-pressure and verdict.
// Depends on slcd_pkg, the block sync_length_crc8_deframer and slcd_frame_checker.
module testbench;
  import slcd_pkg::*;

  // Generous bound; the slowest correct run stays far below.
  localparam int CYCLE_LIMIT   = 1_000_000;
  // Cycles to let pass once no word is expected, covering a body byte still in the CRC unit.
  localparam int SETTLE_CYCLES = 24;
  // Index 3 names no register; a write there must change nothing.
  localparam logic [CFG_INDEX_W-1:0] CFG_NO_REG = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int stall_left  = 0;
  bit idle_on     = 1'b1;

  // Copy of the register values, so that the stimulus can build frames that fit them.
  logic [BYTE_W-1:0] cur_sync = SYNC_VALUE_RST;
  int                cur_max  = MAX_LENGTH_RST;
  int                cur_tmo  = TIMEOUT_TICKS_RST;

  sync_length_crc8_deframer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  slcd_frame_checker frame_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #1 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // The watchdog: a hung block or a lost word ends the run here.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  // Output back-pressure. Whenever no burst is running, a new stall burst may start, its length
  // drawn at random into stall_left; bursts stop entirely once idling is switched off.
  always @(posedge clk) begin
    if (idle_on && stall_left == 0 && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 11);
    end
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Same CRC-8 step as the link uses, here only to build the CRC bytes of the stimulus frames.
  function automatic logic [BYTE_W-1:0] next_crc(input logic [BYTE_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // Presents one input word and returns at the edge where it is accepted. Valid is never
  // lowered here after an acceptance, so back-to-back words keep valid high without a glitch;
  // an idle burst lowers it first and raises it again in a later time step.
  task automatic send_word(input logic cmd, input logic [BYTE_W-1:0] b);
    in_item_t w;
    w.cmd     = cmd;
    w.rx_byte = b;
    if (idle_on && $urandom_range(0, 6) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_tick();
    send_word(CMD_TICK, 8'($urandom));
  endtask

  // Sends a complete frame. The payload of a zero-length frame is the single filler byte,
  // which stays outside the CRC. Ticks may fall between any two bytes of the frame.
  task automatic send_frame(input int len, input bit good_crc, input int tick_pct);
    logic [BYTE_W-1:0] crc;
    logic [BYTE_W-1:0] b;
    int                nbytes;
    crc    = '0;
    nbytes = (len == 0) ? 1 : len;
    send_word(CMD_BYTE, cur_sync);
    if ($urandom_range(0, 99) < tick_pct) send_tick();
    send_word(CMD_BYTE, 8'(len));
    for (int k = 0; k < nbytes; k++) begin
      b = 8'($urandom);
      if (k < len) crc = next_crc(crc, b);
      if ($urandom_range(0, 99) < tick_pct) send_tick();
      send_word(CMD_BYTE, b);
    end
    if ($urandom_range(0, 99) < tick_pct) send_tick();
    send_word(CMD_BYTE, good_crc ? crc : 8'($urandom));
  endtask

  // Lowers valid, waits until every predicted word has come out, then lets the block finish
  // any body byte still in its serial CRC unit.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all three registers back to back, optionally followed by a write to the unused
  // index, and then drops the write enable once.
  task automatic set_config(input logic [BYTE_W-1:0] sync, input int max_len,
                            input int tmo, input bit poke_unused);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SYNC_VALUE;
    cfg_data  <= CFG_DATA_W'(sync);
    @(posedge clk);
    cfg_index <= CFG_MAX_LENGTH;
    cfg_data  <= CFG_DATA_W'(max_len);
    @(posedge clk);
    cfg_index <= CFG_TIMEOUT_TICKS;
    cfg_data  <= CFG_DATA_W'(tmo);
    @(posedge clk);
    if (poke_unused) begin
      cfg_index <= CFG_NO_REG;
      cfg_data  <= '1;
      @(posedge clk);
    end
    cfg_we   <= 1'b0;
    cur_sync = sync;
    cur_max  = max_len;
    cur_tmo  = tmo;
  endtask

  // Random traffic: mostly well-formed frames with random bodies and stray ticks, the rest
  // oversized length bytes, frames cut short and left to time out, and line noise.
  task automatic run_traffic(input int n_items);
    int count;
    int pick;
    int lim;
    int len;
    int cut;
    count = 0;
    lim   = (cur_max < 64) ? cur_max : 64;
    while (count < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5, 6: len = $urandom_range(0, (lim < 6) ? lim : 6);
          7, 8:                len = $urandom_range(0, lim);
          default:             len = lim;
        endcase
        send_frame(len, $urandom_range(0, 9) != 0, 8);
        count += ((len == 0) ? 1 : len) + 3;
      end else if (pick < 78) begin
        send_word(CMD_BYTE, cur_sync);
        send_word(CMD_BYTE, 8'($urandom_range(lim + 1, 255)));
        count += 2;
      end else if (pick < 88) begin
        // A frame that stops partway, followed by enough ticks to run out a short timeout.
        len = $urandom_range(1, (lim < 1) ? 1 : lim);
        cut = $urandom_range(0, len - 1);
        send_word(CMD_BYTE, cur_sync);
        send_word(CMD_BYTE, 8'((lim == 0) ? 0 : len));
        for (int k = 0; k < cut; k++) send_word(CMD_BYTE, 8'($urandom));
        repeat (((cur_tmo < 10) ? cur_tmo : 10) + 1) send_tick();
        count += cut + 2;
      end else begin
        if ($urandom_range(0, 1) == 0) send_tick();
        else send_word(CMD_BYTE, 8'($urandom));
        count++;
      end
    end
  endtask

  initial begin
    logic [BYTE_W-1:0] crc;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words with the reset register values: sync 0, length limit 64, timeout 100.
    // Zero-length frame with a matching CRC of zero, then one with a mismatch.
    send_word(CMD_BYTE, 8'h00);
    send_word(CMD_BYTE, 8'h00);
    send_word(CMD_BYTE, 8'hFF);
    send_word(CMD_BYTE, 8'h00);
    send_word(CMD_BYTE, 8'h00);
    send_word(CMD_BYTE, 8'h00);
    send_word(CMD_BYTE, 8'h00);
    send_word(CMD_BYTE, 8'h5A);
    // A length just above the limit sends the block back to hunting.
    send_word(CMD_BYTE, 8'h00);
    send_word(CMD_BYTE, 8'd65);
    // A tick while hunting does nothing.
    send_tick();
    // Two extreme body bytes with a wrong CRC byte.
    crc = next_crc(next_crc(8'h00, 8'h00), 8'hFF);
    send_word(CMD_BYTE, 8'h00);
    send_word(CMD_BYTE, 8'h02);
    send_word(CMD_BYTE, 8'h00);
    send_word(CMD_BYTE, 8'hFF);
    send_word(CMD_BYTE, ~crc);
    // One body byte with a tick inside the frame, and a matching CRC.
    send_word(CMD_BYTE, 8'h00);
    send_word(CMD_BYTE, 8'h01);
    send_tick();
    send_word(CMD_BYTE, 8'h80);
    send_word(CMD_BYTE, next_crc(8'h00, 8'h80));
    // A non-sync byte while hunting is dropped.
    send_word(CMD_BYTE, 8'h55);
    settle();

    // Timeout at its top value: a frame survives a run of ticks inside it.
    set_config(8'hA5, 64, 65535, 1'b0);
    idle_on = 1'b0;
    crc = next_crc(next_crc(8'h00, 8'h3C), 8'hC3);
    send_word(CMD_BYTE, 8'hA5);
    send_word(CMD_BYTE, 8'h02);
    send_word(CMD_BYTE, 8'h3C);
    repeat (20) send_tick();
    send_word(CMD_BYTE, 8'hC3);
    send_word(CMD_BYTE, crc);
    idle_on = 1'b1;
    send_frame(64, 1'b1, 0);
    run_traffic(50);
    settle();

    // Only empty bodies fit, and any tick inside a frame drops it.
    set_config(8'hFF, 0, 0, 1'b0);
    run_traffic(30);
    settle();

    // Short frames and a short timeout.
    set_config(8'($urandom), 16, 3, 1'b0);
    run_traffic(50);
    settle();

    // A limit above the body store size: length bytes above 64 are still refused.
    set_config(8'h00, 100, 5, 1'b1);
    send_word(CMD_BYTE, 8'h00);
    send_word(CMD_BYTE, 8'd70);
    run_traffic(40);
    settle();

    // Last stretch at full rate on both sides.
    set_config(8'($urandom), 64, 100, 1'b0);
    idle_on = 1'b0;
    send_frame(64, 1'b1, 0);
    run_traffic(50);
    settle();

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* sync_length_crc8_deframer.f */
src/slcd_pkg.sv
src/slcd_ram.sv
src/slcd_crc_serial.sv
src/sync_length_crc8_deframer.sv
test/slcd_frame_checker.sv
test/testbench.sv
